### hdl/bblur_pkg.sv
// shared types and constants of the 3x3 rgb box blur
// no dependencies

package bblur_pkg;

    localparam int CH_W       = 8;
    localparam int PIX_W      = 3 * CH_W;
    localparam int SUM_W      = 12;
    localparam int CFG_W      = 11;
    localparam int DIV9_MUL_W = 13;
    localparam int DIV9_MUL   = 7282;
    localparam int DIV9_SHIFT = 16;
    localparam int OUT_DEPTH  = 8;
    localparam int PTR_W      = $clog2(OUT_DEPTH);
    localparam int CNT_W      = $clog2(OUT_DEPTH + 1);

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;
    localparam logic KIND_PIXEL       = 1'b0;
    localparam logic KIND_FLUSH       = 1'b1;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
        logic            frame_end;
    } result_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } border_mask_t;

endpackage

### hdl/bblur_if.sv
// valid/ready channels of the box blur: source pixels and blurred results
// depends on bblur_pkg

interface bblur_in_if;
    logic                      valid;
    logic                      ready;
    logic                      item_kind;
    logic [bblur_pkg::CH_W-1:0] in_red;
    logic [bblur_pkg::CH_W-1:0] in_green;
    logic [bblur_pkg::CH_W-1:0] in_blue;

    modport source (output valid, output item_kind, output in_red, output in_green,
                    output in_blue, input ready);
    modport sink (input valid, input item_kind, input in_red, input in_green,
                  input in_blue, output ready);
endinterface

interface bblur_out_if;
    logic                      valid;
    logic                      ready;
    logic [bblur_pkg::CH_W-1:0] out_red;
    logic [bblur_pkg::CH_W-1:0] out_green;
    logic [bblur_pkg::CH_W-1:0] out_blue;
    logic                      frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_end, input ready);
    modport sink (input valid, input out_red, input out_green, input out_blue,
                  input frame_end, output ready);
endinterface

### hdl/bblur_line_ram.sv
// simple dual-port line memory, one write and one registered read per cycle
// no dependencies

module bblur_line_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 48
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

endmodule

### hdl/bblur_out_fifo.sv
// result queue of the box blur, drives the output channel
// depends on bblur_pkg and bblur_out_if

module bblur_out_fifo (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  bblur_pkg::result_t             push_data,
    output logic [bblur_pkg::CNT_W-1:0]    count,
    bblur_out_if.source                    result
);

    localparam int                      Depth = bblur_pkg::OUT_DEPTH;
    localparam logic [bblur_pkg::PTR_W-1:0] PTR_LAST = bblur_pkg::PTR_W'(Depth - 1);

    bblur_pkg::result_t            entry_reg [Depth];
    logic [bblur_pkg::PTR_W-1:0]   wr_ptr_reg;
    logic [bblur_pkg::PTR_W-1:0]   rd_ptr_reg;
    logic [bblur_pkg::CNT_W-1:0]   count_reg;
    logic [bblur_pkg::CNT_W-1:0]   count_next;
    logic                          pop;
    bblur_pkg::result_t            head;

    assign pop  = result.valid && result.ready;
    assign head = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + bblur_pkg::CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - bblur_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0
                                                       : wr_ptr_reg + bblur_pkg::PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0
                                                       : rd_ptr_reg + bblur_pkg::PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign count            = count_reg;
    assign result.valid     = (count_reg != '0);
    assign result.out_red   = head.red;
    assign result.out_green = head.green;
    assign result.out_blue  = head.blue;
    assign result.frame_end = head.frame_end;

endmodule

### hdl/box_blur_3x3_rgb_core.sv
// top level of the streaming 3x3 rgb box blur
// depends on bblur_pkg, bblur_if, bblur_line_ram and bblur_out_fifo

// Takes one pixel item per clock while ready is high, in raster order, and returns
// the 3x3 box average of each channel (out-of-frame neighbors count as zero, sum
// always divided by 9), the result for pixel p coming with the item that carries
// pixel p+W+1; W+1 flush items after the frame drain the rest. An accepted item's
// result passes stages s1 to s3 and the result queue to the output. The sustained
// rate is one item per cycle, set by the line memory: one read of the two rows
// above at the accepting edge and one write-back in the cycle after, with
// forwarding when the same column is read again at once (one-pixel-wide frames).
// Ready falls only when the eight entry result queue plus the three pipeline
// stages would overflow. The line memory needs no clearing pass: unwritten
// entries only reach masked neighbors. A configuration write restarts the frame.

module box_blur_3x3_rgb_core #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wen,
    input  logic                        cfg_index,
    input  logic [bblur_pkg::CFG_W-1:0] cfg_wdata,
    bblur_in_if.sink                    pixel,
    bblur_out_if.source                 result
);

    localparam int CfgW  = bblur_pkg::CFG_W;
    localparam int PixW  = bblur_pkg::PIX_W;
    localparam int ChW   = bblur_pkg::CH_W;
    localparam int SumW  = bblur_pkg::SUM_W;
    localparam int MemW  = 2 * PixW;
    localparam int ProdW = SumW + bblur_pkg::DIV9_MUL_W;
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int IR_W  = $clog2(MAX_HEIGHT + 3);
    localparam int WD_W  = ($clog2(MAX_WIDTH + 1) > CfgW) ? $clog2(MAX_WIDTH + 1) : CfgW;
    localparam int HD_W  = ($clog2(MAX_HEIGHT + 1) > CfgW) ? $clog2(MAX_HEIGHT + 1) : CfgW;
    localparam int OCC_W = bblur_pkg::CNT_W + 1;

    logic [CfgW-1:0]  frame_width_reg;
    logic [CfgW-1:0]  frame_height_reg;
    logic [COL_W-1:0] in_col_reg;
    logic [IR_W-1:0]  in_row_reg;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;

    logic [WD_W-1:0]  fw_ext;
    logic [HD_W-1:0]  fh_ext;
    logic [WD_W-1:0]  w_eff;
    logic [HD_W-1:0]  h_eff;
    logic [WD_W-1:0]  w_m1;
    logic [HD_W-1:0]  h_m1;
    logic [COL_W-1:0] col_eff;
    logic [WD_W-1:0]  col_inc;
    logic             col_wrap;
    logic [WD_W-1:0]  out_col_inc;
    logic             emit;
    logic             last;
    bblur_pkg::border_mask_t mask;
    logic             accept;
    logic [PixW-1:0]  pix;

    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_last_reg;
    bblur_pkg::border_mask_t s1_mask_reg;
    logic [COL_W-1:0] s1_addr_reg;
    logic [PixW-1:0]  s1_pix_reg;
    logic             fwd_hit_reg;
    logic [MemW-1:0]  fwd_data_reg;
    logic [MemW-1:0]  rd_data;
    logic [MemW-1:0]  line_entry;
    logic [PixW-1:0]  top_pix;
    logic [PixW-1:0]  mid_pix;
    logic [MemW-1:0]  wb_data;

    logic [PixW-1:0]  win_reg [3][3];

    logic             s2_valid_reg;
    logic             s2_last_reg;
    bblur_pkg::border_mask_t s2_mask_reg;
    logic [SumW-1:0]  sum [3];

    logic             s3_valid_reg;
    logic             s3_last_reg;
    logic [SumW-1:0]  s3_sum_reg [3];
    logic [ProdW-1:0] prod [3];
    logic [ChW-1:0]   quot [3];
    bblur_pkg::result_t push_data;

    logic [bblur_pkg::CNT_W-1:0] fifo_count;
    logic [OCC_W-1:0] occupancy;

    // frame geometry
    always_comb
    begin
        fw_ext = WD_W'(frame_width_reg);
        fh_ext = HD_W'(frame_height_reg);
        if (fw_ext == '0)
        begin
            w_eff = WD_W'(1);
        end
        else if (fw_ext > WD_W'(MAX_WIDTH))
        begin
            w_eff = WD_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = fw_ext;
        end
        if (fh_ext == '0)
        begin
            h_eff = HD_W'(1);
        end
        else if (fh_ext > HD_W'(MAX_HEIGHT))
        begin
            h_eff = HD_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = fh_ext;
        end
    end

    assign w_m1        = w_eff - WD_W'(1);
    assign h_m1        = h_eff - HD_W'(1);
    assign col_eff     = (WD_W'(in_col_reg) >= w_eff) ? '0 : in_col_reg;
    assign col_inc     = WD_W'(col_eff) + WD_W'(1);
    assign col_wrap    = (col_inc >= w_eff);
    assign out_col_inc = WD_W'(out_col_reg) + WD_W'(1);
    assign emit        = (in_row_reg >= IR_W'(2)) ||
                         ((in_row_reg == IR_W'(1)) && (col_eff != '0));
    assign last        = (WD_W'(out_col_reg) == w_m1) && (HD_W'(out_row_reg) == h_m1);
    assign mask.top    = (out_row_reg == '0);
    assign mask.bottom = (HD_W'(out_row_reg) >= h_m1);
    assign mask.left   = (out_col_reg == '0);
    assign mask.right  = (WD_W'(out_col_reg) >= w_m1);

    assign accept = pixel.valid && pixel.ready;
    assign pix    = (pixel.item_kind == bblur_pkg::KIND_FLUSH) ? '0
                                                    : {pixel.in_red, pixel.in_green,
                                                       pixel.in_blue};

    // registers and position counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= CfgW'(800);
            frame_height_reg <= CfgW'(600);
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                bblur_pkg::REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata;
                bblur_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata;
                default: ;
            endcase
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
        end
        else if (accept)
        begin
            if (emit && last)
            begin
                in_col_reg  <= '0;
                in_row_reg  <= '0;
                out_col_reg <= '0;
                out_row_reg <= '0;
            end
            else
            begin
                if (col_wrap)
                begin
                    in_col_reg <= '0;
                    in_row_reg <= in_row_reg + IR_W'(1);
                end
                else
                begin
                    in_col_reg <= col_inc[COL_W-1:0];
                end
                if (emit)
                begin
                    if (out_col_inc >= w_eff)
                    begin
                        out_col_reg <= '0;
                        out_row_reg <= out_row_reg + ROW_W'(1);
                    end
                    else
                    begin
                        out_col_reg <= out_col_inc[COL_W-1:0];
                    end
                end
            end
        end
    end

    // line memory: each column entry holds the two rows above
    bblur_line_ram #(
        .DEPTH (MAX_WIDTH),
        .WIDTH (MemW)
    ) u_line_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (col_eff),
        .rd_data (rd_data),
        .wr_en   (s1_valid_reg),
        .wr_addr (s1_addr_reg),
        .wr_data (wb_data)
    );

    assign line_entry = fwd_hit_reg ? fwd_data_reg : rd_data;
    assign top_pix    = line_entry[MemW-1:PixW];
    assign mid_pix    = line_entry[PixW-1:0];
    assign wb_data    = {mid_pix, s1_pix_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_emit_reg  <= accept && emit;
            s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_last_reg  <= last;
            s1_mask_reg  <= mask;
            s1_addr_reg  <= col_eff;
            s1_pix_reg   <= pix;
            // same column still being written back
            fwd_hit_reg  <= s1_valid_reg && (s1_addr_reg == col_eff);
            fwd_data_reg <= wb_data;
        end
        s2_last_reg <= s1_last_reg;
        s2_mask_reg <= s1_mask_reg;
        s3_last_reg <= s2_last_reg;
        for (int ch = 0; ch < 3; ch++)
        begin
            s3_sum_reg[ch] <= sum[ch];
        end
    end

    // 3x3 window, newest column on the right
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else if (s1_valid_reg)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= top_pix;
            win_reg[1][2] <= mid_pix;
            win_reg[2][2] <= s1_pix_reg;
        end
    end

    // masked neighborhood sums
    always_comb
    begin
        logic use_tap;
        for (int ch = 0; ch < 3; ch++)
        begin
            sum[ch] = '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    use_tap = !((r == 0) && s2_mask_reg.top) &&
                              !((r == 2) && s2_mask_reg.bottom) &&
                              !((k == 0) && s2_mask_reg.left) &&
                              !((k == 2) && s2_mask_reg.right);
                    sum[ch] = sum[ch] + (use_tap ? SumW'(win_reg[r][k][(2 - ch) * ChW +: ChW])
                                                 : SumW'(0));
                end
            end
        end
    end

    // divide by 9 through the reciprocal
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            prod[ch] = ProdW'(s3_sum_reg[ch]) * ProdW'(bblur_pkg::DIV9_MUL);
            quot[ch] = prod[ch][bblur_pkg::DIV9_SHIFT +: ChW];
        end
    end

    assign push_data.red       = quot[0];
    assign push_data.green     = quot[1];
    assign push_data.blue      = quot[2];
    assign push_data.frame_end = s3_last_reg;

    bblur_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s3_valid_reg),
        .push_data (push_data),
        .count     (fifo_count),
        .result    (result)
    );

    assign occupancy = OCC_W'(fifo_count) + OCC_W'(s1_valid_reg) + OCC_W'(s2_valid_reg) +
                       OCC_W'(s3_valid_reg);
    assign pixel.ready = (occupancy < OCC_W'(bblur_pkg::OUT_DEPTH));

endmodule

### hdl/bblur_checker.sv
// port-level checks of the box blur and their binding to the top level
// depends on box_blur_3x3_rgb_core

module bblur_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_red,
    input logic [7:0] out_green,
    input logic [7:0] out_blue,
    input logic       out_frame_end
);

    logic [15:0] pending_reg;
    logic        in_acc;
    logic        out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // items taken in but not yet answered, results never outnumber them
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else if (in_acc && !out_acc)
        begin
            pending_reg <= (pending_reg == 16'hFFFF) ? pending_reg : pending_reg + 16'd1;
        end
        else if (out_acc && !in_acc && pending_reg != '0)
        begin
            pending_reg <= pending_reg - 16'd1;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result withdrawn before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_red) && $stable(out_green) &&
                                    $stable(out_blue) && $stable(out_frame_end))
        else $error("stalled result changed");

    a_no_extra: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("result offered without an accepted item behind it");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("result offered during reset");

endmodule

bind box_blur_3x3_rgb_core bblur_checker u_bblur_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (pixel.valid),
    .in_ready      (pixel.ready),
    .out_valid     (result.valid),
    .out_ready     (result.ready),
    .out_red       (result.out_red),
    .out_green     (result.out_green),
    .out_blue      (result.out_blue),
    .out_frame_end (result.frame_end)
);
